@@ hdl/tdpt_pkg.sv @@
// Shared constants for the trial-division prime test block.
// No dependencies; imported by the top level and the checker.
`default_nettype none
package tdpt_pkg;

    // working width of the candidate
    localparam int VALUE_WIDTH = 32;
    // squared divisor runs one step past the candidate, so keep two spare bits
    localparam int SQ_WIDTH = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    localparam int IN_WIDTH = 32;
    localparam int OUT_TDATA_WIDTH = 8;

    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(5);
    localparam logic [VALUE_WIDTH-1:0] DIVISOR_THREE = VALUE_WIDTH'(3);
    localparam logic [SQ_WIDTH-1:0] FIRST_SQUARE = SQ_WIDTH'(25);
    localparam logic [SQ_WIDTH-1:0] SQUARE_STEP_CONST = SQ_WIDTH'(36);

endpackage
`default_nettype wire

@@ hdl/trial_division_prime_test_top.sv @@
// Top level of the trial-division prime test: sequencer plus one serial remainder unit.
// Depends on tdpt_pkg.
`default_nettype none

// One candidate in, one is_prime flag out. Zero, one, two, three and even
// candidates are answered without division. Any other candidate is tested by a
// single restoring remainder unit that works one quotient bit a cycle: first
// by 3, then by each pair 6k-1 and 6k+1 while the squared divisor stays at or
// below the candidate, with a bound check before each pair. The input is not
// ready while a candidate is under test; a finished result waits in the
// output register and a new candidate is accepted meanwhile.
module trial_division_prime_test_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [31:0] candidate
    input  wire logic [tdpt_pkg::IN_WIDTH-1:0]         s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [0] is_prime, [7:1] zero
    output logic [tdpt_pkg::OUT_TDATA_WIDTH-1:0]       m_tdata
);
    import tdpt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] PH_THREE = 2'd0;
    localparam logic [1:0] PH_LO    = 2'd1;
    localparam logic [1:0] PH_HI    = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;

    logic [VALUE_WIDTH-1:0] cand;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] rem_step;
    logic                   s_accept;
    logic                   slot_free;

    // keep the low VALUE_WIDTH bits, zero-extend if the port is narrower
    assign cand = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, s_tdata});

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    // one restoring step of the shared remainder unit
    assign trial = {rem_reg, n_reg[cnt_reg]};
    always_comb begin
        if (trial >= {1'b0, div_reg}) begin
            rem_step = VALUE_WIDTH'(trial - {1'b0, div_reg});
        end else begin
            rem_step = trial[VALUE_WIDTH-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    n_next   = cand;
                    d_next   = FIRST_DIVISOR;
                    sq_next  = FIRST_SQUARE;
                    div_next = DIVISOR_THREE;
                    rem_next = '0;
                    cnt_next = CNT_WIDTH'(VALUE_WIDTH - 1);
                    phase_next = PH_THREE;
                    if (cand == VALUE_WIDTH'(2) || cand == VALUE_WIDTH'(3)) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (cand <= VALUE_WIDTH'(1) || !cand[0]) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == '0) begin
                    rem_next = '0;
                    cnt_next = CNT_WIDTH'(VALUE_WIDTH - 1);
                    if (rem_step == '0) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        unique case (phase_reg)
                            PH_LO: begin
                                div_next   = d_reg + VALUE_WIDTH'(2);
                                phase_next = PH_HI;
                            end
                            PH_HI: begin
                                // advance to the next pair: (d+6)^2 = d^2 + 12d + 36
                                d_next  = d_reg + VALUE_WIDTH'(6);
                                sq_next = sq_reg + SQ_WIDTH'({d_reg, 3'b000})
                                        + SQ_WIDTH'({d_reg, 2'b00}) + SQUARE_STEP_CONST;
                                state_next = ST_CHECK;
                            end
                            default: begin
                                state_next = ST_CHECK;
                            end
                        endcase
                    end
                end
            end
            ST_CHECK: begin
                if (sq_reg > SQ_WIDTH'(n_reg)) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    div_next   = d_reg;
                    phase_next = PH_LO;
                    state_next = ST_DIV;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_prime_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        phase_reg     <= phase_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_WIDTH-1){1'b0}}, out_prime_reg};

endmodule
`default_nettype wire

@@ hdl/tdpt_checker.sv @@
// Port-level assertions for the trial-division prime test top level, and its bind.
// Depends on tdpt_pkg and trial_division_prime_test_top.
`default_nettype none
module tdpt_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [tdpt_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata
);
    import tdpt_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // padding bits of the result stay zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_WIDTH-1:1] == '0)
        else $error("result padding not zero");

    // busy right after taking a candidate
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    // a new result only appears while the input side is busy
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a candidate under test");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/tb_trial_division_prime_test_top.sv @@
// Self-checking testbench for trial_division_prime_test_top: streams candidates in,
// checks every is_prime flag against an in-bench 6k+/-1 trial-division predictor.
// Depends on tdpt_pkg and the top level in hdl/.
`default_nettype none

module tb_trial_division_prime_test_top;
    import tdpt_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_TAIL = 15;
    localparam int DRAIN_CYCLES = 20;
    // the largest 32-bit prime is the slowest candidate; leave ample margin for the rest
    localparam longint TIMEOUT_CYCLES = 64'd12_000_000;
    localparam longint unsigned VALUE_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH);
    localparam longint unsigned FIRST_TRIAL = 64'd5;
    localparam longint unsigned WHEEL_STEP = 64'd6;

    typedef struct {
        logic [IN_WIDTH-1:0] candidate;
        bit                  is_prime;
    } verdict_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // [31:0] candidate
    logic [IN_WIDTH-1:0]        s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // [0] is_prime, [7:1] zero
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;

    logic [IN_WIDTH-1:0] candidates_to_send[$];
    verdict_t            expected_verdicts[$];
    int                  item_total = 0;
    int                  sent_count = 0;
    int                  verdicts_seen = 0;
    int                  mismatches = 0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    bit                  in_fire = 1'b0;
    bit                  out_fire = 1'b0;

    trial_division_prime_test_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic bit prime_verdict(input logic [IN_WIDTH-1:0] raw);
        longint unsigned n;
        longint unsigned d;
        n = 64'(raw) & VALUE_MASK;
        if (n == 2 || n == 3)
            return 1'b1;
        if (n <= 1 || n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        // d <= n / d keeps the bound free of overflow at any width
        for (d = FIRST_TRIAL; d <= n / d; d += WHEEL_STEP) begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // sample both channels; fire flags are consumed at the following falling edge
    always @(posedge aclk) begin
        verdict_t want;
        in_fire = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (out_fire) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.is_prime)
                    flag_mismatch($sformatf("candidate %0d: is_prime=%b, want %b",
                                            want.candidate, m_tdata[0], want.is_prime));
                if (m_tdata[OUT_TDATA_WIDTH-1:1] !== '0)
                    flag_mismatch($sformatf("candidate %0d: padding bits %h not zero",
                                            want.candidate, m_tdata));
            end
        end
        if (in_fire) begin
            want.candidate = s_tdata;
            want.is_prime = prime_verdict(s_tdata);
            expected_verdicts.insert(expected_verdicts.size(), want);
        end
    end

    // input side: hold until the transaction is taken, then maybe idle a burst
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            s_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap--;
        end else if (candidates_to_send.size() > 0) begin
            s_tdata <= candidates_to_send.pop_front();
            s_tvalid <= 1'b1;
            sent_count++;
            if (sent_count < item_total - QUIET_TAIL && $urandom_range(3, 0) == 0)
                send_gap = $urandom_range(12, 1);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side: random backpressure bursts, none near the end
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (verdicts_seen < item_total - QUIET_TAIL && $urandom_range(4, 0) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(12, 1) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        logic [IN_WIDTH-1:0] cand;
        int unsigned         factor;
        int unsigned         pick;
        int unsigned         small_primes[$] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                                 41, 43, 47, 53, 59, 61, 67, 71, 73, 79,
                                                 83, 89, 97};

        // zero, one, tiny values, squares that land exactly on the loop bound,
        // hits on both halves of the wheel, and the top of the range
        candidates_to_send = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
                               32'd9, 32'd25, 32'd35, 32'd49, 32'd77, 32'd91, 32'd121,
                               32'd143, 32'd169, 32'd63001, 32'd65521, 32'd65537,
                               32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                               32'd4294967291};
        // mostly small operands so primes resolve fast; full-width ones carry
        // a small factor so they stay cheap while toggling the upper bits
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                cand = $urandom_range(32'h0000_FFFF, 0);
            end else if (pick < 80) begin
                cand = $urandom_range(32'h00FF_FFFF, 0);
            end else if (pick < 95) begin
                factor = small_primes[$urandom_range(small_primes.size() - 1, 0)];
                cand = factor * $urandom_range(32'hFFFF_FFFF / factor, 1);
            end else begin
                cand = $urandom_range(255, 0);
            end
            candidates_to_send.insert(candidates_to_send.size(), cand);
        end
        item_total = candidates_to_send.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (candidates_to_send.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("trial_division_prime_test_top regression: pass");
        else
            $display("trial_division_prime_test_top regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("trial_division_prime_test_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/tdpt_pkg.sv
hdl/trial_division_prime_test_top.sv
hdl/tdpt_checker.sv
tb/tb_trial_division_prime_test_top.sv
